// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Simulation builds get the property checks; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/core/tsema_pkg.sv =====
// Types and constants for the timestamped EMA history core.
// No dependencies; used by tsema_ctrl, tsema_dpath and the top level.
package tsema_pkg;

    localparam int STAMP_W = 32;
    localparam int VALUE_W = 32;
    localparam int GAMMA_W = 17;
    localparam int STAT_W  = 3;
    localparam logic [GAMMA_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_HELD       = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_BURNED = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE      = 3'd3;
    localparam logic [STAT_W-1:0] ST_STALE      = 3'd4;

    localparam logic [1:0] REG_GAMMA      = 2'd0;
    localparam logic [1:0] REG_HOLD_OFF   = 2'd1;
    localparam logic [1:0] REG_BURN_IN    = 2'd2;
    localparam logic [1:0] REG_CACHE_SPAN = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_U_CHECK,
        S_U_NEWEST,
        S_U_MUL_B,
        S_U_ACC_B,
        S_U_WRITE,
        S_U_TRIM_RD,
        S_U_TRIM_CMP,
        S_Q_CHECK,
        S_Q_LOW,
        S_Q_HIGH,
        S_Q_SCAN_RD,
        S_Q_SCAN_CMP,
        S_Q_MUL_LO,
        S_Q_MUL_HI,
        S_Q_ACC_HI,
        S_Q_DIV_INIT,
        S_Q_DIV,
        S_Q_FIX,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MUL_AVG_G,
        MUL_REW_G,
        MUL_DV_LO,
        MUL_DV_HI
    } t_mul_sel;

    typedef enum logic [1:0] {
        ADDR_NEWEST,
        ADDR_OLDEST,
        ADDR_K
    } t_addr_sel;

    typedef enum logic [1:0] {
        RES_CODE,
        RES_AVG,
        RES_HIT,
        RES_INTERP
    } t_res_sel;

    typedef struct packed {
        logic              latch;
        logic              upd_begin;
        logic              cap_newest;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              acc_load;
        logic              acc_add;
        logic              acc_shift;
        logic              write_hist;
        logic              drop_oldest;
        logic              k_clr;
        logic              k_inc;
        logic              lo_cap;
        logic              hi_cap;
        logic              div_init;
        logic              div_step;
        logic              res_set;
        t_res_sel          res_sel;
        logic [STAT_W-1:0] res_status;
        logic              load_out;
        t_addr_sel         addr_sel;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic held;
        logic stale;
        logic burned;
        logic empty;
        logic rd_lt;
        logic rd_eq;
        logic rd_gt;
        logic k_zero;
        logic trim_drop;
        logic div_last;
    } t_status;

endpackage

// ===== rtl/core/tsema_dpath.sv =====
// Datapath: history memories, average, burn-in state, shared multiplier,
// restoring divider and result registers. Depends on tsema_pkg.
`include "assert_macros.svh"
module tsema_dpath
    import tsema_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_sts,
    input  logic [2*STAMP_W-1:0]      i_s_tdata,
    input  logic                      i_s_tuser,
    input  logic [GAMMA_W-1:0]        i_gamma,
    input  logic [STAMP_W-1:0]        i_hold_off,
    input  logic [STAMP_W-1:0]        i_warm_span,
    input  logic [STAMP_W-1:0]        i_cache_span,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [STAT_W-1:0]         o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [CW:0] sum);
        logic [CW:0] adj;
        adj = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
        return adj[AW-1:0];
    endfunction

    logic [STAMP_W-1:0]        mem_stamp [DEPTH];
    logic signed [VALUE_W-1:0] mem_value [DEPTH];

    logic [STAMP_W-1:0]        r_stamp;
    logic signed [VALUE_W-1:0] r_reward;
    logic [AW-1:0]             r_oldest;
    logic [CW-1:0]             r_count;
    logic signed [VALUE_W-1:0] r_average;
    logic                      r_avg_valid;
    logic                      r_delay_started;
    logic [STAMP_W-1:0]        r_delay_start;
    logic                      r_burn_started;
    logic [STAMP_W-1:0]        r_burn_start;
    logic [STAMP_W-1:0]        r_burn_last;
    logic [STAMP_W-1:0]        r_stamp_rd;
    logic signed [VALUE_W-1:0] r_value_rd;
    logic                      r_same;
    logic [CW-1:0]             r_k;
    logic [STAMP_W-1:0]        r_lo_stamp;
    logic signed [VALUE_W-1:0] r_lo_val;
    logic                      r_neg;
    logic [VALUE_W:0]          r_dv_mag;
    logic [STAMP_W-1:0]        r_dt;
    logic [STAMP_W-1:0]        r_span;
    logic signed [51:0]        r_p;
    logic signed [65:0]        r_acc;
    logic [STAMP_W-1:0]        r_rem;
    logic [STAMP_W:0]          r_dlow;
    logic [STAMP_W:0]          r_quo;
    logic [5:0]                r_dcnt;
    logic signed [VALUE_W-1:0] r_res_value;
    logic [STAT_W-1:0]         r_res_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [STAT_W-1:0]         r_out_status;

    logic [GAMMA_W-1:0]        g;
    logic [AW-1:0]             newest_slot;
    logic [AW-1:0]             append_slot;
    logic [AW-1:0]             k_slot;
    logic [AW-1:0]             oldest_next;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic                      full;
    logic [STAMP_W-1:0]        eff_start;
    logic signed [33:0]        mul_a;
    logic signed [17:0]        mul_b;
    logic signed [65:0]        acc_term;
    logic signed [65:0]        rounded;
    logic signed [VALUE_W-1:0] new_avg;
    logic signed [VALUE_W:0]   dv;
    logic [65:0]               dividend;
    logic [33:0]               trial;
    logic signed [VALUE_W-1:0] interp;

    assign g           = (i_gamma > ONE_Q16) ? ONE_Q16 : i_gamma;
    assign full        = (r_count == DEPTH_C);
    assign newest_slot = f_wrap((CW + 1)'(r_oldest) + (CW + 1)'(r_count - CW'(1)));
    assign k_slot      = f_wrap((CW + 1)'(r_oldest) + (CW + 1)'(r_k));
    assign oldest_next = f_wrap((CW + 1)'(r_oldest) + (CW + 1)'(1));
    assign append_slot = full ? r_oldest : f_wrap((CW + 1)'(r_oldest) + (CW + 1)'(r_count));
    assign wr_addr     = r_same ? newest_slot : append_slot;
    assign eff_start   = r_delay_started ? r_delay_start : r_stamp;

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_NEWEST: rd_addr = newest_slot;
            ADDR_OLDEST: rd_addr = r_oldest;
            ADDR_K:      rd_addr = k_slot;
            default:     rd_addr = r_oldest;
        endcase
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_AVG_G: begin
                mul_a = 34'(r_average);
                mul_b = 18'($signed({1'b0, g}));
            end
            MUL_REW_G: begin
                mul_a = 34'(r_reward);
                mul_b = 18'($signed({1'b0, ONE_Q16 - g}));
            end
            MUL_DV_LO: begin
                mul_a = $signed({1'b0, r_dv_mag});
                mul_b = $signed({2'b00, r_dt[15:0]});
            end
            MUL_DV_HI: begin
                mul_a = $signed({1'b0, r_dv_mag});
                mul_b = $signed({2'b00, r_dt[31:16]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_term = i_cmd.acc_shift ? (66'(r_p) <<< 16) : 66'(r_p);
    assign rounded  = r_acc + 66'sd32768;
    assign new_avg  = r_avg_valid ? rounded[47:16] : r_reward;
    assign dv       = 33'(r_value_rd) - 33'(r_lo_val);
    assign dividend = 66'(r_acc) + 66'(r_span >> 1);
    assign trial    = {1'b0, r_rem, r_dlow[STAMP_W]} - {2'b00, r_span};
    assign interp   = r_neg ? (r_lo_val - $signed(r_quo[VALUE_W-1:0]))
                            : (r_lo_val + $signed(r_quo[VALUE_W-1:0]));

    always_comb begin
        o_sts.func      = i_s_tuser;
        o_sts.held      = (r_stamp < eff_start) || ((r_stamp - eff_start) < i_hold_off);
        o_sts.stale     = (r_count != '0) && (r_stamp_rd > r_stamp);
        o_sts.burned    = r_burn_started && !(r_burn_last < r_burn_start) &&
                          ((r_burn_last - r_burn_start) > i_warm_span);
        o_sts.empty     = (r_count == '0);
        o_sts.rd_lt     = (r_stamp_rd < r_stamp);
        o_sts.rd_eq     = (r_stamp_rd == r_stamp);
        o_sts.rd_gt     = (r_stamp_rd > r_stamp);
        o_sts.k_zero    = (r_k == '0);
        o_sts.trim_drop = ((r_stamp - r_stamp_rd) > i_cache_span);
        o_sts.div_last  = (r_dcnt == 6'd32);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_hist) begin
            mem_stamp[wr_addr] <= r_stamp;
            mem_value[wr_addr] <= new_avg;
        end
        r_stamp_rd <= mem_stamp[rd_addr];
        r_value_rd <= mem_value[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest        <= '0;
            r_count         <= '0;
            r_average       <= '0;
            r_avg_valid     <= 1'b0;
            r_delay_started <= 1'b0;
            r_delay_start   <= '0;
            r_burn_started  <= 1'b0;
            r_burn_start    <= '0;
            r_burn_last     <= '0;
        end else begin
            if (i_cmd.upd_begin) begin
                if (!r_burn_started) begin
                    r_burn_started <= 1'b1;
                    r_burn_start   <= r_stamp;
                end
                r_burn_last <= r_stamp;
                if (!r_delay_started) begin
                    r_delay_started <= 1'b1;
                    r_delay_start   <= r_stamp;
                end
            end
            if (i_cmd.write_hist) begin
                r_average   <= new_avg;
                r_avg_valid <= 1'b1;
                if (!r_same) begin
                    if (full) begin
                        r_oldest <= oldest_next;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
            end
            if (i_cmd.drop_oldest) begin
                r_oldest <= oldest_next;
                r_count  <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_stamp  <= i_s_tdata[STAMP_W-1:0];
            r_reward <= $signed(i_s_tdata[2*STAMP_W-1:STAMP_W]);
        end
        if (i_cmd.cap_newest) begin
            r_same <= (r_count != '0) && (r_stamp_rd == r_stamp);
        end
        if (i_cmd.mul_en) begin
            r_p <= mul_a * mul_b;
        end
        if (i_cmd.acc_load) begin
            r_acc <= 66'(r_p);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + acc_term;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.lo_cap) begin
            r_lo_stamp <= r_stamp_rd;
            r_lo_val   <= r_value_rd;
        end
        if (i_cmd.hi_cap) begin
            r_neg    <= dv[VALUE_W];
            r_dv_mag <= dv[VALUE_W] ? 33'(-dv) : 33'(dv);
            r_dt     <= r_stamp - r_lo_stamp;
            r_span   <= r_stamp_rd - r_lo_stamp;
        end
        if (i_cmd.div_init) begin
            r_rem  <= dividend[64:33];
            r_dlow <= dividend[32:0];
            r_quo  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[33]) begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[STAMP_W-1:0], 1'b1};
            end else begin
                r_rem <= {r_rem[STAMP_W-2:0], r_dlow[STAMP_W]};
                r_quo <= {r_quo[STAMP_W-1:0], 1'b0};
            end
            r_dlow <= {r_dlow[STAMP_W-1:0], 1'b0};
            r_dcnt <= r_dcnt + 6'd1;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_sel)
                RES_CODE:   r_res_value <= '0;
                RES_AVG:    r_res_value <= new_avg;
                RES_HIT:    r_res_value <= r_value_rd;
                RES_INTERP: r_res_value <= interp;
                default:    r_res_value <= '0;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    `ASSERT_NEVER(a_count_le_depth, i_clk, i_rst_n, r_count > DEPTH_C)
    `ASSERT_CLK(a_drop_nonempty, i_clk, i_rst_n, i_cmd.drop_oldest |-> (r_count > CW'(1)))
    `ASSERT_NEVER(a_write_and_drop, i_clk, i_rst_n, i_cmd.write_hist && i_cmd.drop_oldest)

endmodule

// ===== rtl/core/tsema_ctrl.sv =====
// Controller state machine: sequences updates, queries and result hand-off.
// Depends on tsema_pkg; drives tsema_dpath through t_cmd.
`include "assert_macros.svh"
module tsema_ctrl
    import tsema_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    output logic    o_m_axis_tvalid,
    input  logic    i_m_axis_tready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == S_IDLE) && i_s_axis_tvalid;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_s_axis_tvalid) n_state = i_sts.func ? S_Q_CHECK : S_U_CHECK;
            S_U_CHECK:    n_state = i_sts.held ? S_FINISH : S_U_NEWEST;
            S_U_NEWEST:   n_state = i_sts.stale ? S_FINISH : S_U_MUL_B;
            S_U_MUL_B:    n_state = S_U_ACC_B;
            S_U_ACC_B:    n_state = S_U_WRITE;
            S_U_WRITE:    n_state = S_U_TRIM_RD;
            S_U_TRIM_RD:  n_state = S_U_TRIM_CMP;
            S_U_TRIM_CMP: n_state = i_sts.trim_drop ? S_U_TRIM_RD : S_FINISH;
            S_Q_CHECK:    n_state = (!i_sts.burned || i_sts.empty) ? S_FINISH : S_Q_LOW;
            S_Q_LOW:      n_state = i_sts.rd_gt ? S_FINISH : S_Q_HIGH;
            S_Q_HIGH:     n_state = i_sts.rd_lt ? S_FINISH : S_Q_SCAN_RD;
            S_Q_SCAN_RD:  n_state = S_Q_SCAN_CMP;
            S_Q_SCAN_CMP: begin
                if (i_sts.rd_lt) begin
                    n_state = S_Q_SCAN_RD;
                end else if (i_sts.rd_eq || i_sts.k_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_Q_MUL_LO;
                end
            end
            S_Q_MUL_LO:   n_state = S_Q_MUL_HI;
            S_Q_MUL_HI:   n_state = S_Q_ACC_HI;
            S_Q_ACC_HI:   n_state = S_Q_DIV_INIT;
            S_Q_DIV_INIT: n_state = S_Q_DIV;
            S_Q_DIV:      if (i_sts.div_last) n_state = S_Q_FIX;
            S_Q_FIX:      n_state = S_FINISH;
            S_FINISH:     if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_OLDEST;
        o_cmd.mul_sel  = MUL_AVG_G;
        o_cmd.res_sel  = RES_CODE;
        o_cmd.res_status = ST_OK;
        o_cmd.latch    = accept;
        case (r_state)
            S_U_CHECK: begin
                o_cmd.upd_begin  = 1'b1;
                o_cmd.addr_sel   = ADDR_NEWEST;
                o_cmd.res_set    = i_sts.held;
                o_cmd.res_status = ST_HELD;
            end
            S_U_NEWEST: begin
                o_cmd.cap_newest = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = MUL_AVG_G;
                o_cmd.res_set    = i_sts.stale;
                o_cmd.res_status = ST_STALE;
            end
            S_U_MUL_B: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_REW_G;
            end
            S_U_ACC_B: begin
                o_cmd.acc_add = 1'b1;
            end
            S_U_WRITE: begin
                o_cmd.write_hist = 1'b1;
                o_cmd.res_set    = 1'b1;
                o_cmd.res_sel    = RES_AVG;
            end
            S_U_TRIM_RD: begin
                o_cmd.addr_sel = ADDR_OLDEST;
            end
            S_U_TRIM_CMP: begin
                o_cmd.drop_oldest = i_sts.trim_drop;
            end
            S_Q_CHECK: begin
                o_cmd.addr_sel   = ADDR_OLDEST;
                o_cmd.res_set    = !i_sts.burned || i_sts.empty;
                o_cmd.res_status = i_sts.burned ? ST_RANGE : ST_NOT_BURNED;
            end
            S_Q_LOW: begin
                o_cmd.addr_sel   = ADDR_NEWEST;
                o_cmd.res_set    = i_sts.rd_gt;
                o_cmd.res_status = ST_RANGE;
            end
            S_Q_HIGH: begin
                o_cmd.k_clr      = 1'b1;
                o_cmd.res_set    = i_sts.rd_lt;
                o_cmd.res_status = ST_RANGE;
            end
            S_Q_SCAN_RD: begin
                o_cmd.addr_sel = ADDR_K;
            end
            S_Q_SCAN_CMP: begin
                o_cmd.lo_cap  = i_sts.rd_lt;
                o_cmd.k_inc   = i_sts.rd_lt;
                o_cmd.hi_cap  = !i_sts.rd_lt;
                o_cmd.res_set = !i_sts.rd_lt && (i_sts.rd_eq || i_sts.k_zero);
                o_cmd.res_sel = RES_HIT;
            end
            S_Q_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DV_LO;
            end
            S_Q_MUL_HI: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_DV_HI;
            end
            S_Q_ACC_HI: begin
                o_cmd.acc_add   = 1'b1;
                o_cmd.acc_shift = 1'b1;
            end
            S_Q_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
            end
            S_Q_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_Q_FIX: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_sel = RES_INTERP;
            end
            S_FINISH: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd.latch = accept;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    `ASSERT_CLK(a_accept_starts, i_clk, i_rst_n, accept |=> (r_state == S_U_CHECK || r_state == S_Q_CHECK))
    `ASSERT_NEVER(a_load_when_full, i_clk, i_rst_n, o_cmd.load_out && r_out_valid && !i_m_axis_tready)
    `ASSERT_CLK(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out |=> (o_m_axis_tvalid && r_state == S_IDLE))

endmodule

// ===== rtl/core/timestamped_ema_history_core.sv =====
// Timestamped EMA history core: APB register bank, controller and datapath.
// Depends on tsema_pkg, tsema_ctrl and tsema_dpath.
//
// Input stream: tuser carries func (0 update, 1 query); tdata carries the
// stamp and, for updates, a Q16.16 reward. Every beat gives one result beat
// with the new average, the stored or interpolated value, or zero for an
// error status, in tdata and a status in tuser. One item is in flight at a
// time; tready is high only while the core idles. Update: hold-off and
// staleness checks, multiply/accumulate of the average, the write, then a
// read and compare of the oldest entry, repeated while the cache span check
// drops it; tready rises with the result beat. Query: 3 range checks, a scan
// of the stored entries up to and including the bracket, multiply/accumulate
// steps, a 33-step restoring divider and a closing fix-up step.
// The result sits in an output register; while a stalled receiver holds it,
// the next beat is still taken and processed, but the core then holds its
// result and takes no further beat until the register frees.
// Reset clears the ring pointers, count, average and burn-in state; the
// history memories keep their content and need no clearing pass.
// Registers (APB, 4-byte stride): gamma, hold-off, warm-up span,
// cache_span; write them only while the core is idle.
module timestamped_ema_history_core
    import tsema_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // stamp[31:0], reward[63:32]
    input  logic        i_s_axis_tuser,   // func[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // value[31:0]
    output logic [2:0]  o_m_axis_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [GAMMA_W-1:0]        r_gamma;
    logic [STAMP_W-1:0]        r_hold_off;
    logic [STAMP_W-1:0]        r_warm_span;
    logic [STAMP_W-1:0]        r_cache_span;
    logic                      cfg_wr;
    logic [1:0]                reg_idx;
    t_cmd                      cmd;
    t_status                   sts;
    logic signed [VALUE_W-1:0] res_value;
    logic [STAT_W-1:0]         res_status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma      <= 17'd62259;
            r_hold_off   <= '0;
            r_warm_span  <= '0;
            r_cache_span <= 32'd1000;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_GAMMA:      r_gamma      <= pwdata[GAMMA_W-1:0];
                REG_HOLD_OFF:   r_hold_off   <= pwdata;
                REG_BURN_IN:    r_warm_span  <= pwdata;
                REG_CACHE_SPAN: r_cache_span <= pwdata;
                default:        r_cache_span <= r_cache_span;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAMMA:      prdata = 32'(r_gamma);
            REG_HOLD_OFF:   prdata = r_hold_off;
            REG_BURN_IN:    prdata = r_warm_span;
            REG_CACHE_SPAN: prdata = r_cache_span;
            default:        prdata = '0;
        endcase
    end

    tsema_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    tsema_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_gamma      (r_gamma),
        .i_hold_off   (r_hold_off),
        .i_warm_span  (r_warm_span),
        .i_cache_span (r_cache_span),
        .o_value      (res_value),
        .o_status     (res_status)
    );

    assign o_m_axis_tdata = res_value;
    assign o_m_axis_tuser = res_status;

endmodule
